>>> hw/rtl/lbo_pkg.sv
package lbo_pkg;

    // Defaults and fixed field widths
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int PIX_W         = 24;
    localparam int CFG_W         = 12;
    localparam int ROW_W         = CFG_W + 1;   // row reaches height+1 on the tail
    localparam int LINE_W        = 3 * PIX_W;   // {label row r-1, picture row r-1, label row r-2}
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [PIX_W-1:0] MARK_RESET   = {PIX_W{1'b1}};
    localparam logic [CFG_W-1:0] MIN_DIM      = CFG_W'(3);

    // Register map, word index
    typedef enum logic [ADDR_W-3:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_MARK_COLOR   = 2'd2
    } reg_idx_t;

    // Per-item position flags handed from the front stage to the window stage
    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } pos_flags_t;

    // Width saturated to 3..maxw
    function automatic logic [31:0] clamp_width(input logic [CFG_W-1:0] iw,
                                                input int unsigned maxw);
        logic [31:0] v;
        v = 32'(iw);
        if (v < 32'd3) begin
            v = 32'd3;
        end
        if (v > 32'(maxw)) begin
            v = 32'(maxw);
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/lbo_ram.sv
module lbo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lbo_cfg.sv
module lbo_cfg #(
    parameter int MAX_WIDTH = lbo_pkg::MAX_WIDTH_DEF,
    localparam int WID_W = $clog2(MAX_WIDTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbo_pkg::ADDR_W-1:0]  paddr,
    input  logic [lbo_pkg::DATA_W-1:0]  pwdata,
    output logic [lbo_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [WID_W-1:0]            eff_width,
    output logic [lbo_pkg::CFG_W-1:0]   eff_height,
    output logic [lbo_pkg::PIX_W-1:0]   mark_color,
    output logic                        restart
);
    import lbo_pkg::*;

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [PIX_W-1:0] mark_color_reg;
    logic             wr_en;
    reg_idx_t         idx;
    logic [31:0]      eff_w32;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            mark_color_reg   <= MARK_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CFG_W-1:0];
                REG_MARK_COLOR:   mark_color_reg   <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // A write to either dimension starts a new frame
    always_comb begin
        restart = 1'b0;
        if (wr_en) begin
            unique case (idx) inside
                REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_reg);
            REG_MARK_COLOR:   prdata = DATA_W'(mark_color_reg);
            default:          prdata = '0;
        endcase
    end

    // Saturated frame dimensions
    assign eff_w32    = clamp_width(image_width_reg, MAX_WIDTH);
    assign eff_width  = eff_w32[WID_W-1:0];
    assign eff_height = (image_height_reg < MIN_DIM) ? MIN_DIM : image_height_reg;
    assign mark_color = mark_color_reg;

endmodule

>>> hw/rtl/lbo_pos.sv
module lbo_pos #(
    parameter int MAX_WIDTH = lbo_pkg::MAX_WIDTH_DEF,
    localparam int WID_W = $clog2(MAX_WIDTH + 1),
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       restart,
    input  logic [WID_W-1:0]           eff_width,
    input  logic [lbo_pkg::CFG_W-1:0]  eff_height,
    input  logic                       accept,
    input  logic [lbo_pkg::PIX_W-1:0]  label_pixel,
    input  logic [lbo_pkg::PIX_W-1:0]  picture_pixel,
    input  logic                       flush,
    output logic [COL_W-1:0]           item_col,
    output logic [lbo_pkg::PIX_W-1:0]  item_lab,
    output logic [lbo_pkg::PIX_W-1:0]  item_pic,
    output lbo_pkg::pos_flags_t        item_flags
);
    import lbo_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] h_ext;
    logic [WID_W-1:0] c_ext;
    logic [WID_W-1:0] cc;
    logic [ROW_W-1:0] cr;
    logic             c_zero;
    logic             zero_data;
    logic             row_end;

    assign h_ext  = ROW_W'(eff_height);
    assign c_ext  = WID_W'(col_reg);
    assign c_zero = (col_reg == '0);

    // Flush items and tail items carry zero data
    assign zero_data = flush | (row_reg >= h_ext);
    assign item_lab  = zero_data ? '0 : label_pixel;
    assign item_pic  = zero_data ? '0 : picture_pixel;
    assign item_col  = col_reg;

    // Centre of the window: one column back, wrapping to the row before
    assign cc = c_zero ? (eff_width - WID_W'(1)) : (c_ext - WID_W'(1));
    assign cr = c_zero ? (row_reg - ROW_W'(2)) : (row_reg - ROW_W'(1));

    assign item_flags.emit = (row_reg >= ROW_W'(2)) | ((row_reg == ROW_W'(1)) & ~c_zero);
    assign item_flags.interior = (cr >= ROW_W'(1)) && (cr <= h_ext - ROW_W'(2)) &&
                                 (cc >= WID_W'(1)) && (cc <= eff_width - WID_W'(2));
    // Final output of a frame sits at column 0 of row height+1
    assign item_flags.last = (row_reg == h_ext + ROW_W'(1)) & c_zero;

    assign row_end = (c_ext + WID_W'(1)) >= eff_width;

    // Raster position of the next item
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (item_flags.last) begin
                col_next = '0;
                row_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> hw/rtl/lbo_win.sv
module lbo_win #(
    parameter int MAX_WIDTH = lbo_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [COL_W-1:0]            item_col,
    input  logic [lbo_pkg::PIX_W-1:0]   item_lab,
    input  logic [lbo_pkg::PIX_W-1:0]   item_pic,
    input  lbo_pkg::pos_flags_t         item_flags,
    input  logic [lbo_pkg::LINE_W-1:0]  rd_data,
    output logic                        wr_en,
    output logic [COL_W-1:0]            wr_addr,
    output logic [lbo_pkg::LINE_W-1:0]  wr_data,
    input  logic [lbo_pkg::PIX_W-1:0]   mark_color,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lbo_pkg::PIX_W-1:0]   m_out_pixel,
    output logic                        m_is_boundary,
    output logic                        m_frame_last
);
    import lbo_pkg::*;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_lab_reg;
    logic [PIX_W-1:0] s1_pic_reg;
    pos_flags_t       s1_flags_reg;

    logic [PIX_W-1:0] win_reg  [9];
    logic [PIX_W-1:0] win_next [9];
    logic [PIX_W-1:0] prev_pic_reg;

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_pixel_reg;
    logic             m_boundary_reg;
    logic             m_last_reg;

    logic [PIX_W-1:0] above_lab;
    logic [PIX_W-1:0] above_pic;
    logic [PIX_W-1:0] above2_lab;
    logic             out_free;
    logic             s1_fire;
    logic             accept;
    logic             diff;
    logic             boundary;

    // Handshake: stage 1 drains unless its result finds the output register full
    assign out_free = ~m_valid_reg | m_ready;
    assign s1_fire  = s1_valid_reg & (out_free | ~s1_flags_reg.emit);
    assign s_ready  = ~s1_valid_reg | s1_fire;
    assign accept   = s_valid & s_ready;

    // Line memory word read for this column
    assign above_lab  = rd_data[LINE_W-1 -: PIX_W];
    assign above_pic  = rd_data[LINE_W-PIX_W-1 -: PIX_W];
    assign above2_lab = rd_data[PIX_W-1:0];

    // Write back: current row becomes line 1, old line 1 label moves to line 2
    assign wr_en   = s1_fire;
    assign wr_addr = s1_col_reg;
    assign wr_data = {s1_lab_reg, s1_pic_reg, above_lab};

    // Window shift
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3 + 1] = win_reg[k*3+2];
        end
        win_next[2] = above2_lab;
        win_next[5] = above_lab;
        win_next[8] = s1_lab_reg;
    end

    // Any neighbor label differing from the centre
    always_comb begin
        diff = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && win_next[k] != win_next[4]) begin
                diff = 1'b1;
            end
        end
    end
    assign boundary = diff & s1_flags_reg.interior;

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg   <= item_col;
            s1_lab_reg   <= item_lab;
            s1_pic_reg   <= item_pic;
            s1_flags_reg <= item_flags;
        end
    end

    // Window and centre picture pixel; the previous item's line-1 picture is the centre
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= win_next[k];
            end
            prev_pic_reg <= above_pic;
        end
    end

    // Output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_flags_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (s1_fire && s1_flags_reg.emit) begin
            m_pixel_reg    <= boundary ? mark_color : prev_pic_reg;
            m_boundary_reg <= boundary;
            m_last_reg     <= s1_flags_reg.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_pixel   = m_pixel_reg;
    assign m_is_boundary = m_boundary_reg;
    assign m_frame_last  = m_last_reg;

endmodule

>>> hw/rtl/label_boundary_overlay_top.sv
// Label boundary overlay.
// Input channel (s_*): one label-map pixel and the matching picture pixel per
// transfer, in raster order; s_flush marks a dummy item that only pushes.
// Output channel (m_*): the picture pixel, or the mark color where an interior
// pixel's 3x3 label window holds a label other than the centre one. The final
// pixel of a frame carries m_frame_last.
// Throughput: one transfer per cycle on both channels unless the output stalls;
// the line memory is read at accept and written back as stage 1 drains, one
// access per port per cycle. A pixel's result is released by the item that
// arrives width+1 items after it; m_valid rises as that item leaves stage 1.
// So a frame needs width+1 more items (normally flush items) to drain its tail.
// Frame size is set over the APB port; a write to width or height restarts
// the frame. Reset empties the pipeline and clears the position counters;
// no memory clearing pass runs, since only interior pixels compare labels and
// their windows are always written within the current frame.
// A stalled receiver holds the output register; the stage behind it keeps
// taking items that give no result, and otherwise s_ready drops until the
// output transfer completes.
module label_boundary_overlay_top #(
    parameter int MAX_WIDTH = lbo_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lbo_pkg::ADDR_W-1:0]  paddr,
    input  logic [lbo_pkg::DATA_W-1:0]  pwdata,
    output logic [lbo_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lbo_pkg::PIX_W-1:0]   s_label_pixel,
    input  logic [lbo_pkg::PIX_W-1:0]   s_picture_pixel,
    input  logic                        s_flush,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lbo_pkg::PIX_W-1:0]   m_out_pixel,
    output logic                        m_is_boundary,
    output logic                        m_frame_last
);
    import lbo_pkg::*;

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [WID_W-1:0]  eff_width;
    logic [CFG_W-1:0]  eff_height;
    logic [PIX_W-1:0]  mark_color;
    logic              restart;
    logic              in_accept;
    logic [COL_W-1:0]  item_col;
    logic [PIX_W-1:0]  item_lab;
    logic [PIX_W-1:0]  item_pic;
    pos_flags_t        item_flags;
    logic [LINE_W-1:0] rd_data;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [LINE_W-1:0] wr_data;

    assign in_accept = s_valid & s_ready;

    lbo_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .mark_color (mark_color),
        .restart    (restart)
    );

    lbo_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (restart),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .accept        (in_accept),
        .label_pixel   (s_label_pixel),
        .picture_pixel (s_picture_pixel),
        .flush         (s_flush),
        .item_col      (item_col),
        .item_lab      (item_lab),
        .item_pic      (item_pic),
        .item_flags    (item_flags)
    );

    // Two label lines and one picture line, one word per column
    lbo_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_line_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (in_accept),
        .raddr (item_col),
        .rdata (rd_data)
    );

    lbo_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .item_col      (item_col),
        .item_lab      (item_lab),
        .item_pic      (item_pic),
        .item_flags    (item_flags),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .mark_color    (mark_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_pixel   (m_out_pixel),
        .m_is_boundary (m_is_boundary),
        .m_frame_last  (m_frame_last)
    );

endmodule

>>> hw/rtl/lbo_checker.sv
module lbo_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [lbo_pkg::PIX_W-1:0]   m_out_pixel,
    input logic                        m_is_boundary,
    input logic                        m_frame_last
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Input only backs up behind a stalled output
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without an output stall");

    // A frame has at least nine results, so two frame ends never follow directly
    a_last_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_frame_last) |=> !(m_valid && m_frame_last))
        else $error("frame end on consecutive results");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_pixel) &&
                                   $stable(m_is_boundary) && $stable(m_frame_last)))
        else $error("stalled result changed");

endmodule

bind label_boundary_overlay_top lbo_checker u_lbo_checker (.*);

>>> tb/tb_label_boundary_overlay_top.sv
// One expected output pixel
typedef struct packed {
    logic [23:0] pix;
    logic        bnd;
    logic        last;
} overlay_px_t;

// Predicts the overlay output stream and checks the block's output transfers
class overlay_checker;
    bit [11:0]   width_reg;
    bit [11:0]   height_reg;
    bit [23:0]   mark_reg;
    bit [23:0]   label_prev [lbo_pkg::MAX_WIDTH_DEF];   // labels of row r-1
    bit [23:0]   label_prev2 [lbo_pkg::MAX_WIDTH_DEF];  // labels of row r-2
    bit [23:0]   pic_delay [lbo_pkg::MAX_WIDTH_DEF + 1];
    int unsigned pic_ptr;
    bit [23:0]   win [9];
    int unsigned col;
    int unsigned row;
    int unsigned emitted;
    overlay_px_t pending_pixels [$];
    int          errors;

    function new();
        width_reg  = lbo_pkg::WIDTH_RESET;
        height_reg = lbo_pkg::HEIGHT_RESET;
        mark_reg   = lbo_pkg::MARK_RESET;
        foreach (label_prev[i]) label_prev[i] = '0;
        foreach (label_prev2[i]) label_prev2[i] = '0;
        foreach (pic_delay[i]) pic_delay[i] = '0;
        foreach (win[i]) win[i] = '0;
        errors = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        col     = 0;
        row     = 0;
        emitted = 0;
        pic_ptr = 0;
    endfunction

    function int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w < lbo_pkg::MIN_DIM) w = lbo_pkg::MIN_DIM;
        if (w > lbo_pkg::MAX_WIDTH_DEF) w = lbo_pkg::MAX_WIDTH_DEF;
        return w;
    endfunction

    function int unsigned eff_height();
        return (height_reg < lbo_pkg::MIN_DIM) ? lbo_pkg::MIN_DIM : height_reg;
    endfunction

    // Width and height writes restart the frame; mark color does not
    function void write_reg(lbo_pkg::reg_idx_t idx, logic [31:0] v);
        case (idx)
            lbo_pkg::REG_IMAGE_WIDTH: begin
                width_reg = v[11:0];
                restart_frame();
            end
            lbo_pkg::REG_IMAGE_HEIGHT: begin
                height_reg = v[11:0];
                restart_frame();
            end
            lbo_pkg::REG_MARK_COLOR: begin
                mark_reg = v[23:0];
            end
            default: ;
        endcase
    endfunction

    // Accepted input transfer: advance the window and queue the pixel it releases
    function void take_pixel(logic [23:0] lab_in, logic [23:0] pic_in, logic flush);
        int unsigned w, h, c, r, cc, cr;
        bit [23:0]   lab, pic, above, above2, old_pic, centre;
        bit          emit, bnd, last;
        overlay_px_t px;
        w   = eff_width();
        h   = eff_height();
        c   = col;
        r   = row;
        lab = lab_in;
        pic = pic_in;
        bnd = 1'b0;
        // flush items and tail items carry zero data
        if (flush || r >= h) begin
            lab = '0;
            pic = '0;
        end

        // label column for rows r-2, r-1, r
        above          = label_prev[c];
        above2         = label_prev2[c];
        label_prev2[c] = above;
        label_prev[c]  = lab;
        for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
        end
        win[2] = above2;
        win[5] = above;
        win[8] = lab;

        // picture delay of w+1 items
        if (pic_ptr > w) pic_ptr = 0;
        old_pic            = pic_delay[pic_ptr];
        pic_delay[pic_ptr] = pic;
        pic_ptr            = (pic_ptr >= w) ? 0 : pic_ptr + 1;

        emit = (r >= 2) || (r == 1 && c >= 1);
        if (c + 1 >= w) begin
            col = 0;
            row = r + 1;
        end else begin
            col = c + 1;
        end
        if (!emit) return;

        // position of the released pixel
        if (c >= 1) begin
            cc = c - 1;
            cr = r - 1;
        end else begin
            cc = w - 1;
            cr = r - 2;
        end
        if (cr >= 1 && cr + 2 <= h && cc >= 1 && cc + 2 <= w) begin
            centre = win[4];
            for (int k = 0; k < 9; k++) begin
                if (k != 4 && win[k] != centre) bnd = 1'b1;
            end
        end

        last = (emitted + 1 >= w * h);
        if (last) restart_frame();
        else emitted++;

        px.pix  = bnd ? mark_reg : old_pic;
        px.bnd  = bnd;
        px.last = last;
        pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    // Output transfer against the oldest pending pixel
    function void check_pixel(logic [23:0] pix, logic bnd, logic last);
        overlay_px_t want;
        if (pending_pixels.size() == 0) begin
            errors++;
            $error("m_out_pixel: expected no transfer, got %06h", pix);
            return;
        end
        want = pending_pixels.pop_front();
        if (pix !== want.pix) begin
            errors++;
            $error("m_out_pixel: expected %06h, got %06h", want.pix, pix);
        end
        if (bnd !== want.bnd) begin
            errors++;
            $error("m_is_boundary: expected %0b, got %0b", want.bnd, bnd);
        end
        if (last !== want.last) begin
            errors++;
            $error("m_frame_last: expected %0b, got %0b", want.last, last);
        end
    endfunction
endclass

module tb_label_boundary_overlay_top;
    import lbo_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 300;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [PIX_W-1:0]    s_label_pixel;
    logic [PIX_W-1:0]    s_picture_pixel;
    logic                s_flush;
    logic                m_valid;
    logic                m_ready;
    logic [PIX_W-1:0]    m_out_pixel;
    logic                m_is_boundary;
    logic                m_frame_last;

    overlay_checker      sb;
    int unsigned         cycle_count = 0;
    int                  items_sent = 0;
    bit                  tx_quiet;
    bit                  rx_quiet;
    bit                  hold_req;

    // label layout of the current frame: diagonal blocks from a small palette
    logic [23:0]         palette [4];
    int                  blk_x, blk_y, n_colors, noise_pct;
    bit                  wild_labels;

    label_boundary_overlay_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_label_pixel   (s_label_pixel),
        .s_picture_pixel (s_picture_pixel),
        .s_flush         (s_flush),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_pixel     (m_out_pixel),
        .m_is_boundary   (m_is_boundary),
        .m_frame_last    (m_frame_last)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // transfers on both channels, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_pixel(m_out_pixel, m_is_boundary, m_frame_last);
            if (s_valid && s_ready) sb.take_pixel(s_label_pixel, s_picture_pixel, s_flush);
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [23:0] pick_color();
        case ($urandom_range(0, 3))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void pick_label_layout();
        blk_x       = $urandom_range(1, 4);
        blk_y       = $urandom_range(1, 3);
        n_colors    = $urandom_range(1, 4);
        noise_pct   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
        wild_labels = ($urandom_range(0, 9) == 0);
        foreach (palette[i]) palette[i] = pick_color();
    endfunction

    function automatic logic [23:0] layout_label(int x, int y);
        if (wild_labels || $urandom_range(0, 99) < noise_pct) return 24'($urandom);
        return palette[((x / blk_x) + (y / blk_y)) % n_colors];
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = pick_gap(rx_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
        end
    end

    // One input transfer; called at a falling edge, returns at a falling edge
    // with valid still high
    task automatic send_item(logic [23:0] lab, logic [23:0] pic, logic flush);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_label_pixel   <= lab;
        s_picture_pixel <= pic;
        s_flush         <= flush;
        items_sent++;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic apb_write(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop offering, wait for every pending pixel, then let the pipe settle
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    // One raster frame plus its w+1 tail pushes, cut short after limit items
    task automatic send_frame(int limit);
        int w, h, n;
        w = sb.eff_width();
        h = sb.eff_height();
        n = 0;
        pick_label_layout();
        for (int y = 0; y < h && n < limit; y++) begin
            for (int x = 0; x < w && n < limit; x++) begin
                send_item(layout_label(x, y), 24'($urandom), $urandom_range(0, 49) == 0);
                n++;
            end
        end
        // tail: mostly flush, some with live data that must be ignored
        for (int k = 0; k <= w && n < limit; k++) begin
            send_item(24'($urandom), 24'($urandom), $urandom_range(0, 4) != 0);
            n++;
        end
    endtask

    initial begin
        int          phase, nf, r, lim;
        logic [11:0] wv, hv;
        sb              = new();
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_label_pixel   = '0;
        s_picture_pixel = '0;
        s_flush         = 1'b0;
        tx_quiet        = 1'b1;
        rx_quiet        = 1'b0;
        hold_req        = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset geometry 640x480: start of a frame
        send_frame(700);
        wait_results_done();

        // 3x3 frames with black mark
        tx_quiet = 1'b0;
        apb_write(REG_IMAGE_WIDTH, 32'd3);
        apb_write(REG_IMAGE_HEIGHT, 32'd3);
        apb_write(REG_MARK_COLOR, 32'h0);
        // uniform labels, but a flush at top right zeroes a neighbor label
        for (int k = 0; k < 9; k++)
            send_item(24'hFFFFFF, k[0] ? 24'hFFFFFF : 24'h000000, k == 2);
        for (int k = 0; k < 4; k++)
            send_item(24'hFFFFFF, 24'hFFFFFF, 1'b1);
        // zero labels, no boundary; flush at bottom right zeroes its picture
        for (int k = 0; k < 9; k++)
            send_item(24'h000000, (k == 8) ? 24'hFFFFFF : (k[0] ? 24'h5A5A5A : 24'hA5A5A5),
                      k == 8);
        for (int k = 0; k < 4; k++)
            send_item(24'($urandom), 24'($urandom), 1'b0);
        wait_results_done();

        // small random frames
        phase = 0;
        while (items_sent < 1950) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                r  = $urandom_range(0, 9);
                wv = (r == 0) ? 12'($urandom_range(0, 2)) :
                     (r == 1) ? 12'($urandom_range(13, 40)) : 12'($urandom_range(3, 12));
                r  = $urandom_range(0, 9);
                hv = (r == 0) ? 12'($urandom_range(0, 2)) :
                     (r == 1) ? 12'($urandom_range(9, 20)) : 12'($urandom_range(3, 8));
                apb_write(REG_IMAGE_WIDTH, {($urandom_range(0, 1) ? 20'($urandom) : 20'h0), wv});
                apb_write(REG_IMAGE_HEIGHT, {($urandom_range(0, 1) ? 20'($urandom) : 20'h0), hv});
            end
            if ($urandom_range(0, 1) == 0)
                apb_write(REG_MARK_COLOR, {8'($urandom), pick_color()});
            // receiver holds off while the sender keeps going
            if (phase == 1 || phase == 6) hold_req = 1'b1;
            nf = $urandom_range(1, 3);
            for (int f = 0; f < nf; f++) begin
                lim = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 32'h4000_0000;
                send_frame(lim);
                if ($urandom_range(0, 3) == 0) wait_results_done();
            end
            wait_results_done();
            phase++;
        end

        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lbo_pkg.sv
hw/rtl/lbo_ram.sv
hw/rtl/lbo_cfg.sv
hw/rtl/lbo_pos.sv
hw/rtl/lbo_win.sv
hw/rtl/label_boundary_overlay_top.sv
hw/rtl/lbo_checker.sv
tb/tb_label_boundary_overlay_top.sv
